### src/top_k_min_heap_selector_macros.svh
// assertion macros shared by the top-k min-heap selector modules
`ifndef TOP_K_MIN_HEAP_SELECTOR_MACROS_SVH
`define TOP_K_MIN_HEAP_SELECTOR_MACROS_SVH
`ifndef SYNTHESIS
// property that holds at every edge out of reset
`define TKMH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tkmh assertion failed");
// same-cycle implication
`define TKMH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkmh assertion failed");
// next-cycle implication
`define TKMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkmh assertion failed");
`else
`define TKMH_ASSERT(label, clk, rst, prop)
`define TKMH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TKMH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/tkmh_pkg.sv
// shared types and constants of the top-k min-heap selector
`default_nettype none
package tkmh_pkg;

   // field widths
   localparam int KeyWidth      = 32;
   localparam int PosWidth      = 24;
   localparam int VelWidth      = 24;
   localparam int MassWidth     = 32;
   localparam int CountWidth    = 11;
   localparam int SlotWidth     = 10;
   localparam int CmdWidth      = 2;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 32;

   // command codes
   localparam logic [CmdWidth-1:0] CMD_OFFER = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_READ  = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_CLEAR = 2'd2;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_MASS_CEILING = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TARGET_COUNT = 1'd1;

   // register reset values
   localparam logic [KeyWidth-1:0]   CeilingReset = '1;
   localparam logic [CountWidth-1:0] TargetReset  = 11'd1024;

   // one heap entry
   typedef struct packed {
      logic [KeyWidth-1:0]         key;
      logic [PosWidth-1:0]         x;
      logic [PosWidth-1:0]         y;
      logic [PosWidth-1:0]         z;
      logic signed [VelWidth-1:0]  velocity;
      logic [MassWidth-1:0]        mass;
   } entry_type;

   // memory read selection
   typedef enum logic [2:0] {
      RD_NONE,
      RD_PARENT,
      RD_CHILDREN,
      RD_ROOT,
      RD_SLOT
   } rd_sel_type;

   // memory write selection, always at the hole
   typedef enum logic [1:0] {
      WR_NONE,
      WR_ITEM,
      WR_PARENT,
      WR_CHILD
   } wr_sel_type;

   // hole index update
   typedef enum logic [2:0] {
      HOLE_KEEP,
      HOLE_COUNT,
      HOLE_ZERO,
      HOLE_PARENT,
      HOLE_CHILD
   } hole_sel_type;

   // entry count update
   typedef enum logic [1:0] {
      CNT_KEEP,
      CNT_INC,
      CNT_CLEAR
   } cnt_op_type;

   // result register load
   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_ENTRY,
      OUT_ZERO
   } out_op_type;

   // controller to datapath
   typedef struct packed {
      logic         load;
      logic         set_accepted;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      hole_sel_type hole_sel;
      cnt_op_type   cnt_op;
      out_op_type   out_op;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CmdWidth-1:0] command;
      logic                key_over;
      logic                has_room;
      logic                empty;
      logic                hole_is_root;
      logic                parent_greater;
      logic                child_none;
      logic                child_smaller;
      logic                beats_root;
      logic                slot_in_range;
      logic                out_free;
   } dp_status_type;

endpackage
`default_nettype wire

### src/tkmh_dp.sv
// heap datapath: entry memory, moving item, hole index, count, registers and result
`default_nettype none
`include "top_k_min_heap_selector_macros.svh"
module tkmh_dp #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tkmh_pkg::dp_cmd_type                  cmd,
   output tkmh_pkg::dp_status_type                    status,
   input  wire logic [tkmh_pkg::CmdWidth-1:0]         req_command,
   input  wire logic [tkmh_pkg::KeyWidth-1:0]         req_scattered_key,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_x,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_y,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_z,
   input  wire logic signed [tkmh_pkg::VelWidth-1:0]  req_velocity,
   input  wire logic [tkmh_pkg::MassWidth-1:0]        req_halo_mass,
   input  wire logic [tkmh_pkg::SlotWidth-1:0]        req_read_slot,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_accepted,
   output logic [tkmh_pkg::CountWidth-1:0]            rsp_kept_count,
   output logic [tkmh_pkg::KeyWidth-1:0]              rsp_entry_key,
   output logic [tkmh_pkg::PosWidth-1:0]              rsp_entry_x,
   output logic [tkmh_pkg::PosWidth-1:0]              rsp_entry_y,
   output logic [tkmh_pkg::PosWidth-1:0]              rsp_entry_z,
   output logic signed [tkmh_pkg::VelWidth-1:0]       rsp_entry_velocity,
   output logic [tkmh_pkg::MassWidth-1:0]             rsp_entry_mass,
   input  wire logic                                  csr_valid,
   input  wire logic [tkmh_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [tkmh_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import tkmh_pkg::*;

   localparam int AddrWidth = $clog2(CAPACITY);
   localparam int CntWidth  = $clog2(CAPACITY + 1);

   // storage
   entry_type                  mem [CAPACITY];
   entry_type                  item_ff;
   entry_type                  rd0_ff;
   entry_type                  rd1_ff;
   entry_type                  out_entry_ff;
   logic [CmdWidth-1:0]        command_ff;
   logic [SlotWidth-1:0]       slot_ff;
   logic [AddrWidth-1:0]       hole_ff;
   logic [AddrWidth-1:0]       hole_in;
   logic [CntWidth-1:0]        count_ff;
   logic [CntWidth-1:0]        count_in;
   logic                       accepted_ff;
   logic [KeyWidth-1:0]        ceiling_ff;
   logic [CountWidth-1:0]      target_ff;
   logic                       rsp_valid_ff;
   logic                       out_accepted_ff;
   logic [CountWidth-1:0]      out_count_ff;

   // index arithmetic
   logic [31:0]                count_w;
   logic [31:0]                hole_w;
   logic [31:0]                target_w;
   logic [31:0]                target_eff;
   logic [31:0]                left_w;
   logic [31:0]                right_w;
   logic                       right_ok;
   logic [AddrWidth-1:0]       parent_idx;
   logic [AddrWidth-1:0]       chosen_idx;
   entry_type                  chosen;

   // memory port control
   logic                       rd_en;
   logic [AddrWidth-1:0]       rd_addr0;
   logic [AddrWidth-1:0]       rd_addr1;
   logic                       wr_en;
   entry_type                  wr_data;

   // heap index math and target clamp
   always_comb begin
      count_w    = 32'(count_ff);
      hole_w     = 32'(hole_ff);
      target_w   = 32'(target_ff);
      if (target_w == 32'd0) begin
         target_eff = 32'd1;
      end else if (target_w > 32'(CAPACITY)) begin
         target_eff = 32'(CAPACITY);
      end else begin
         target_eff = target_w;
      end
      left_w     = (hole_w << 1) + 32'd1;
      right_w    = left_w + 32'd1;
      right_ok   = right_w < count_w;
      parent_idx = AddrWidth'((hole_w - 32'd1) >> 1);
      // right child only when strictly smaller
      if (right_ok && (rd0_ff.key > rd1_ff.key)) begin
         chosen     = rd1_ff;
         chosen_idx = AddrWidth'(right_w);
      end else begin
         chosen     = rd0_ff;
         chosen_idx = AddrWidth'(left_w);
      end
   end

   // status back to the controller
   always_comb begin
      status.command        = command_ff;
      status.key_over       = item_ff.key > ceiling_ff;
      status.has_room       = count_w < target_eff;
      status.empty          = count_ff == '0;
      status.hole_is_root   = hole_ff == '0;
      status.parent_greater = rd0_ff.key > item_ff.key;
      status.child_none     = left_w >= count_w;
      status.child_smaller  = chosen.key < item_ff.key;
      status.beats_root     = item_ff.key > rd0_ff.key;
      status.slot_in_range  = 32'(slot_ff) < count_w;
      status.out_free       = !rsp_valid_ff || rsp_ready;
   end

   // read address selection
   always_comb begin
      rd_en    = cmd.rd_sel != RD_NONE;
      rd_addr0 = '0;
      rd_addr1 = '0;
      case (cmd.rd_sel)
         RD_PARENT: begin
            rd_addr0 = parent_idx;
         end
         RD_CHILDREN: begin
            rd_addr0 = AddrWidth'(left_w);
            rd_addr1 = AddrWidth'(right_w);
         end
         RD_SLOT: begin
            rd_addr0 = AddrWidth'(slot_ff);
         end
         default: begin
            rd_addr0 = '0;
         end
      endcase
   end

   // write data selection
   always_comb begin
      wr_en   = cmd.wr_sel != WR_NONE;
      case (cmd.wr_sel)
         WR_PARENT: wr_data = rd0_ff;
         WR_CHILD:  wr_data = chosen;
         default:   wr_data = item_ff;
      endcase
   end

   // hole and count next values
   always_comb begin
      case (cmd.hole_sel)
         HOLE_COUNT:  hole_in = AddrWidth'(count_ff);
         HOLE_ZERO:   hole_in = '0;
         HOLE_PARENT: hole_in = parent_idx;
         HOLE_CHILD:  hole_in = chosen_idx;
         default:     hole_in = hole_ff;
      endcase
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CntWidth'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   // entry memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[hole_ff] <= wr_data;
      end
      if (rd_en) begin
         rd0_ff <= mem[rd_addr0];
         rd1_ff <= mem[rd_addr1];
      end
   end

   // captured request beat and hole
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff.key      <= req_scattered_key;
         item_ff.x        <= req_pos_x;
         item_ff.y        <= req_pos_y;
         item_ff.z        <= req_pos_z;
         item_ff.velocity <= req_velocity;
         item_ff.mass     <= req_halo_mass;
         command_ff       <= req_command;
         slot_ff          <= req_read_slot;
      end
      hole_ff <= hole_in;
   end

   // control state: count, accept flag, registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         accepted_ff <= 1'b0;
         ceiling_ff  <= CeilingReset;
         target_ff   <= TargetReset;
      end else begin
         count_ff <= count_in;
         if (cmd.load) begin
            accepted_ff <= 1'b0;
         end else if (cmd.set_accepted) begin
            accepted_ff <= 1'b1;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_MASS_CEILING: ceiling_ff <= csr_wdata;
               CSR_TARGET_COUNT: target_ff  <= csr_wdata[CountWidth-1:0];
               default: begin
                  ceiling_ff <= ceiling_ff;
               end
            endcase
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_op != OUT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_op != OUT_NONE) begin
         out_accepted_ff <= accepted_ff;
         out_count_ff    <= CountWidth'(count_ff);
         out_entry_ff    <= (cmd.out_op == OUT_ENTRY) ? rd0_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = out_accepted_ff;
   assign rsp_kept_count     = out_count_ff;
   assign rsp_entry_key      = out_entry_ff.key;
   assign rsp_entry_x        = out_entry_ff.x;
   assign rsp_entry_y        = out_entry_ff.y;
   assign rsp_entry_z        = out_entry_ff.z;
   assign rsp_entry_velocity = out_entry_ff.velocity;
   assign rsp_entry_mass     = out_entry_ff.mass;

   // checks
   `TKMH_ASSERT_IMPLY(a_no_result_overrun, clock, reset, (cmd.out_op != OUT_NONE) && rsp_valid_ff, rsp_ready)
   `TKMH_ASSERT_IMPLY(a_grow_only_with_room, clock, reset, cmd.cnt_op == CNT_INC, status.has_room)
   `TKMH_ASSERT_IMPLY(a_write_inside_heap, clock, reset, cmd.wr_sel != WR_NONE, hole_w <= count_w)
   `TKMH_ASSERT(a_count_bound, clock, reset, count_w <= 32'(CAPACITY))

endmodule
`default_nettype wire

### src/tkmh_ctrl.sv
// heap controller: sequences offer, read and clear over the datapath
`default_nettype none
`include "top_k_min_heap_selector_macros.svh"
module tkmh_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire tkmh_pkg::dp_status_type status,
   output tkmh_pkg::dp_cmd_type         dp_cmd
);
   import tkmh_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SU_READ,
      S_SU_CMP,
      S_RP_CMP,
      S_SD_READ,
      S_SD_CMP,
      S_FIN,
      S_OUT,
      S_OUT_ZERO
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and datapath command
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = state_ff == S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.command)
               CMD_OFFER: begin
                  if (status.key_over) begin
                     state_in = S_FIN;
                  end else if (status.has_room) begin
                     // append at the end, then sift up
                     dp_cmd.set_accepted = 1'b1;
                     dp_cmd.hole_sel     = HOLE_COUNT;
                     state_in            = S_SU_READ;
                  end else begin
                     // full: compare against the root
                     dp_cmd.rd_sel   = RD_ROOT;
                     dp_cmd.hole_sel = HOLE_ZERO;
                     state_in        = S_RP_CMP;
                  end
               end
               CMD_READ: begin
                  if (status.slot_in_range) begin
                     dp_cmd.rd_sel = RD_SLOT;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_OUT_ZERO;
                  end
               end
               CMD_CLEAR: begin
                  dp_cmd.cnt_op = CNT_CLEAR;
                  state_in      = S_OUT_ZERO;
               end
               default: begin
                  state_in = S_OUT_ZERO;
               end
            endcase
         end
         S_SU_READ: begin
            if (status.hole_is_root) begin
               dp_cmd.wr_sel = WR_ITEM;
               dp_cmd.cnt_op = CNT_INC;
               state_in      = S_FIN;
            end else begin
               dp_cmd.rd_sel = RD_PARENT;
               state_in      = S_SU_CMP;
            end
         end
         S_SU_CMP: begin
            if (status.parent_greater) begin
               // parent moves down into the hole
               dp_cmd.wr_sel   = WR_PARENT;
               dp_cmd.hole_sel = HOLE_PARENT;
               state_in        = S_SU_READ;
            end else begin
               dp_cmd.wr_sel = WR_ITEM;
               dp_cmd.cnt_op = CNT_INC;
               state_in      = S_FIN;
            end
         end
         S_RP_CMP: begin
            if (status.beats_root) begin
               dp_cmd.set_accepted = 1'b1;
               state_in            = S_SD_READ;
            end else begin
               state_in = S_FIN;
            end
         end
         S_SD_READ: begin
            if (status.child_none) begin
               dp_cmd.wr_sel = WR_ITEM;
               state_in      = S_FIN;
            end else begin
               dp_cmd.rd_sel = RD_CHILDREN;
               state_in      = S_SD_CMP;
            end
         end
         S_SD_CMP: begin
            if (status.child_smaller) begin
               // smaller child moves up into the hole
               dp_cmd.wr_sel   = WR_CHILD;
               dp_cmd.hole_sel = HOLE_CHILD;
               state_in        = S_SD_READ;
            end else begin
               dp_cmd.wr_sel = WR_ITEM;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            if (status.empty) begin
               state_in = S_OUT_ZERO;
            end else begin
               dp_cmd.rd_sel = RD_ROOT;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (status.out_free) begin
               dp_cmd.out_op = OUT_ENTRY;
               state_in      = S_IDLE;
            end
         end
         S_OUT_ZERO: begin
            if (status.out_free) begin
               dp_cmd.out_op = OUT_ZERO;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `TKMH_ASSERT_NEXT(a_one_beat_in_flight, clock, reset, req_valid && req_ready, !req_ready)

endmodule
`default_nettype wire

### src/top_k_min_heap_selector.sv
// Top-k min-heap selector: keeps the entries with the largest keys.
//
// Request channel (req_*): one beat carries a command with its payload.
// Offer inserts a candidate (sift-up while filling, root replacement and
// sift-down once full), read returns a heap slot, clear empties the store.
// Every request beat yields exactly one response beat (rsp_*) with the accept
// flag, the entry count and an entry (the root after an offer).
// Config channel (csr_*): mass ceiling and target count, always ready; the user
// writes it only while no request is in flight (the block does not enforce this).
// Sequence: each request is decoded, then read and clear go straight to the
// result, while an offer walks the heap level by level; each heap level takes
// a memory read step and a compare/write step on the single entry memory, and
// an offer ends by reading the root into the result.
// One request is processed at a time; req_ready rises again once the result
// is loaded into the output register. A stalled receiver leaves one result
// in the output register and at most one more request parked behind it, with
// req_ready low.
// Reset empties the store (count to zero) and restores the registers;
// memory contents are not cleared and need no clearing pass.
`default_nettype none
module top_k_min_heap_selector #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [tkmh_pkg::CmdWidth-1:0]         req_command,
   input  wire logic [tkmh_pkg::KeyWidth-1:0]         req_scattered_key,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_x,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_y,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_z,
   input  wire logic signed [tkmh_pkg::VelWidth-1:0]  req_velocity,
   input  wire logic [tkmh_pkg::MassWidth-1:0]        req_halo_mass,
   input  wire logic [tkmh_pkg::SlotWidth-1:0]        req_read_slot,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_accepted,
   output logic [tkmh_pkg::CountWidth-1:0]            rsp_kept_count,
   output logic [tkmh_pkg::KeyWidth-1:0]              rsp_entry_key,
   output logic [tkmh_pkg::PosWidth-1:0]              rsp_entry_x,
   output logic [tkmh_pkg::PosWidth-1:0]              rsp_entry_y,
   output logic [tkmh_pkg::PosWidth-1:0]              rsp_entry_z,
   output logic signed [tkmh_pkg::VelWidth-1:0]       rsp_entry_velocity,
   output logic [tkmh_pkg::MassWidth-1:0]             rsp_entry_mass,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tkmh_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [tkmh_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import tkmh_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // config writes are always accepted
   assign csr_ready = 1'b1;

   // controller
   tkmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // datapath
   tkmh_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_command        (req_command),
      .req_scattered_key  (req_scattered_key),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_velocity       (req_velocity),
      .req_halo_mass      (req_halo_mass),
      .req_read_slot      (req_read_slot),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_kept_count     (rsp_kept_count),
      .rsp_entry_key      (rsp_entry_key),
      .rsp_entry_x        (rsp_entry_x),
      .rsp_entry_y        (rsp_entry_y),
      .rsp_entry_z        (rsp_entry_z),
      .rsp_entry_velocity (rsp_entry_velocity),
      .rsp_entry_mass     (rsp_entry_mass),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

endmodule
`default_nettype wire

### dv/top_k_heap_monitor.sv
// channel monitor for the top-k min-heap selector: mirrors the heap and checks each response beat
module top_k_heap_monitor #(
   parameter int CAPACITY = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   input  wire logic                                  req_ready,
   input  wire logic [tkmh_pkg::CmdWidth-1:0]         req_command,
   input  wire logic [tkmh_pkg::KeyWidth-1:0]         req_scattered_key,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_x,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_y,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         req_pos_z,
   input  wire logic signed [tkmh_pkg::VelWidth-1:0]  req_velocity,
   input  wire logic [tkmh_pkg::MassWidth-1:0]        req_halo_mass,
   input  wire logic [tkmh_pkg::SlotWidth-1:0]        req_read_slot,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   input  wire logic                                  rsp_accepted,
   input  wire logic [tkmh_pkg::CountWidth-1:0]       rsp_kept_count,
   input  wire logic [tkmh_pkg::KeyWidth-1:0]         rsp_entry_key,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         rsp_entry_x,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         rsp_entry_y,
   input  wire logic [tkmh_pkg::PosWidth-1:0]         rsp_entry_z,
   input  wire logic signed [tkmh_pkg::VelWidth-1:0]  rsp_entry_velocity,
   input  wire logic [tkmh_pkg::MassWidth-1:0]        rsp_entry_mass,
   input  wire logic                                  csr_valid,
   input  wire logic                                  csr_ready,
   input  wire logic [tkmh_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [tkmh_pkg::CsrDataWidth-1:0]     csr_wdata,
   output int                                         results_owed,
   output int                                         mismatch_count
);
   import tkmh_pkg::*;

   // one response beat
   typedef struct packed {
      logic                  accepted;
      logic [CountWidth-1:0] kept;
      entry_type             entry;
   } outcome_type;

   // mirrored store and registers
   entry_type             heap_mem [CAPACITY];
   int unsigned           held;
   logic [KeyWidth-1:0]   ceiling;
   logic [CountWidth-1:0] target;
   outcome_type           awaited [$];

   function automatic void swap_slots(input int unsigned a, input int unsigned b);
      entry_type t;
      t = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
   endfunction

   // applies one request beat to the mirrored heap, returns the response it should give
   function automatic outcome_type select_top_k(input logic [CmdWidth-1:0] cmd,
                                                input entry_type cand,
                                                input logic [SlotWidth-1:0] slot);
      outcome_type res;
      int unsigned lim;
      int unsigned hole;
      int unsigned up;
      int unsigned kid;
      bit          moving;
      res = '0;
      // zero target acts as one, oversize target as the full store
      if (target == 0) lim = 1;
      else if (target > CAPACITY) lim = CAPACITY;
      else lim = target;
      case (cmd)
         CMD_OFFER: begin
            if (cand.key <= ceiling) begin
               if (held < lim) begin
                  // filling: append and sift up, equal keys stay put
                  heap_mem[held] = cand;
                  hole = held;
                  moving = 1'b1;
                  while (moving && hole > 0) begin
                     up = (hole - 1) / 2;
                     if (heap_mem[up].key <= heap_mem[hole].key) moving = 1'b0;
                     else begin
                        swap_slots(up, hole);
                        hole = up;
                     end
                  end
                  held++;
                  res.accepted = 1'b1;
               end else if (held > 0 && cand.key > heap_mem[0].key) begin
                  // full: replace the root and sift down within the held entries
                  heap_mem[0] = cand;
                  hole = 0;
                  moving = 1'b1;
                  while (moving) begin
                     kid = 2 * hole + 1;
                     if (kid >= held) moving = 1'b0;
                     else begin
                        if (kid + 1 < held && heap_mem[kid].key > heap_mem[kid + 1].key) kid++;
                        if (heap_mem[hole].key <= heap_mem[kid].key) moving = 1'b0;
                        else begin
                           swap_slots(hole, kid);
                           hole = kid;
                        end
                     end
                  end
                  res.accepted = 1'b1;
               end
            end
            if (held > 0) res.entry = heap_mem[0];
         end
         CMD_READ: begin
            if (slot < held) res.entry = heap_mem[slot];
         end
         CMD_CLEAR: begin
            held = 0;
         end
         default: ;
      endcase
      res.kept = held[CountWidth-1:0];
      return res;
   endfunction

   // watch all three channels at each edge
   always @(posedge clock) begin : watch
      outcome_type seen;
      outcome_type want;
      entry_type   cand;
      bit          orphan;
      int          delta;
      if (reset) begin
         held = 0;
         ceiling = CeilingReset;
         target = TargetReset;
         awaited.delete();
         mismatch_count = 0;
         results_owed <= 0;
      end else begin
         delta = 0;
         // register write beat
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MASS_CEILING) ceiling = csr_wdata[KeyWidth-1:0];
            else target = csr_wdata[CountWidth-1:0];
         end
         // response beat against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            seen.accepted = rsp_accepted;
            seen.kept = rsp_kept_count;
            seen.entry.key = rsp_entry_key;
            seen.entry.x = rsp_entry_x;
            seen.entry.y = rsp_entry_y;
            seen.entry.z = rsp_entry_z;
            seen.entry.velocity = rsp_entry_velocity;
            seen.entry.mass = rsp_entry_mass;
            orphan = (awaited.size() == 0);
            if (orphan) want = '0;
            else want = awaited.pop_front();
            if (orphan || seen !== want) begin
               if (mismatch_count < 10)
                  $display("rsp mismatch%s: exp acc=%0d cnt=%0d key=%h x=%h y=%h z=%h vel=%h mass=%h",
                           orphan ? " (none expected)" : "", want.accepted, want.kept,
                           want.entry.key, want.entry.x, want.entry.y, want.entry.z,
                           want.entry.velocity, want.entry.mass);
               if (mismatch_count < 10)
                  $display("             got acc=%0d cnt=%0d key=%h x=%h y=%h z=%h vel=%h mass=%h",
                           seen.accepted, seen.kept, seen.entry.key, seen.entry.x,
                           seen.entry.y, seen.entry.z, seen.entry.velocity, seen.entry.mass);
               mismatch_count++;
            end
            delta = delta - 1;
         end
         // request beat
         if (req_valid && req_ready) begin
            cand.key = req_scattered_key;
            cand.x = req_pos_x;
            cand.y = req_pos_y;
            cand.z = req_pos_z;
            cand.velocity = req_velocity;
            cand.mass = req_halo_mass;
            awaited.push_back(select_top_k(req_command, cand, req_read_slot));
            delta = delta + 1;
         end
         results_owed <= results_owed + delta;
      end
   end

endmodule

### dv/top_k_min_heap_selector_tb.sv
// testbench top for the top-k min-heap selector: stimulus, idling and verdict
module top_k_min_heap_selector_tb;
   import tkmh_pkg::*;

   localparam logic [CmdWidth-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_MAX     = 18;
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int DRAIN_CYCLES = 40;
   localparam int CAPACITY     = 1024;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [CmdWidth-1:0]           req_command = CMD_OFFER;
   logic [KeyWidth-1:0]           req_scattered_key = '0;
   logic [PosWidth-1:0]           req_pos_x = '0;
   logic [PosWidth-1:0]           req_pos_y = '0;
   logic [PosWidth-1:0]           req_pos_z = '0;
   logic signed [VelWidth-1:0]    req_velocity = '0;
   logic [MassWidth-1:0]          req_halo_mass = '0;
   logic [SlotWidth-1:0]          req_read_slot = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_accepted;
   logic [CountWidth-1:0]         rsp_kept_count;
   logic [KeyWidth-1:0]           rsp_entry_key;
   logic [PosWidth-1:0]           rsp_entry_x;
   logic [PosWidth-1:0]           rsp_entry_y;
   logic [PosWidth-1:0]           rsp_entry_z;
   logic signed [VelWidth-1:0]    rsp_entry_velocity;
   logic [MassWidth-1:0]          rsp_entry_mass;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CsrIndexWidth-1:0]      csr_index = CSR_MASS_CEILING;
   logic [CsrDataWidth-1:0]       csr_wdata = '0;
   int                            results_owed;
   int                            mismatch_count;
   bit                            sender_busy = 1'b1;
   bit                            receiver_busy = 1'b1;

   always #2 clock = ~clock;

   top_k_min_heap_selector #(.CAPACITY(CAPACITY)) u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_command, .req_scattered_key,
      .req_pos_x, .req_pos_y, .req_pos_z, .req_velocity, .req_halo_mass, .req_read_slot,
      .rsp_valid, .rsp_ready, .rsp_accepted, .rsp_kept_count, .rsp_entry_key,
      .rsp_entry_x, .rsp_entry_y, .rsp_entry_z, .rsp_entry_velocity, .rsp_entry_mass,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   top_k_heap_monitor #(.CAPACITY(CAPACITY)) u_monitor (
      .clock, .reset,
      .req_valid, .req_ready, .req_command, .req_scattered_key,
      .req_pos_x, .req_pos_y, .req_pos_z, .req_velocity, .req_halo_mass, .req_read_slot,
      .rsp_valid, .rsp_ready, .rsp_accepted, .rsp_kept_count, .rsp_entry_key,
      .rsp_entry_x, .rsp_entry_y, .rsp_entry_z, .rsp_entry_velocity, .rsp_entry_mass,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .results_owed, .mismatch_count
   );

   // one request beat after an optional gap, returns at the accepting edge
   task automatic send_fields(input logic [CmdWidth-1:0] cmd, input logic [KeyWidth-1:0] key,
                              input logic [PosWidth-1:0] x, input logic [PosWidth-1:0] y,
                              input logic [PosWidth-1:0] z,
                              input logic signed [VelWidth-1:0] vel,
                              input logic [MassWidth-1:0] mass,
                              input logic [SlotWidth-1:0] slot);
      int unsigned gap;
      gap = sender_busy ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_command <= cmd;
      req_scattered_key <= key;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_velocity <= vel;
      req_halo_mass <= mass;
      req_read_slot <= slot;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop offering and wait until every owed response has come back
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] index,
                                 input logic [CsrDataWidth-1:0] data);
      quiesce();
      csr_index <= index;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // random traffic under one register setting, mostly offers with tie-prone keys
   task automatic random_phase(input logic [KeyWidth-1:0] ceiling,
                               input logic [CountWidth-1:0] target,
                               input int items, input int clear_pct,
                               input bit send_idle, input bit recv_idle);
      int unsigned roll;
      int unsigned pick;
      int unsigned span;
      logic [CmdWidth-1:0]  cmd;
      logic [KeyWidth-1:0]  key;
      logic [SlotWidth-1:0] slot;
      write_register(CSR_MASS_CEILING, ceiling);
      write_register(CSR_TARGET_COUNT, CsrDataWidth'(target));
      sender_busy = send_idle;
      receiver_busy = recv_idle;
      if (target == 0) span = 1;
      else if (target > CAPACITY) span = CAPACITY;
      else span = 32'(target);
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < clear_pct) cmd = CMD_CLEAR;
         else if (roll < clear_pct + 1) cmd = CMD_UNUSED;
         else if (roll < clear_pct + 13) cmd = CMD_READ;
         else cmd = CMD_OFFER;
         pick = $urandom_range(0, 9);
         if (pick < 5) key = $urandom;
         else if (pick < 7) key = $urandom_range(0, 7);
         else if (pick == 7) key = ceiling + $urandom_range(0, 1);
         else if (pick == 8) key = '1;
         else key = $urandom_range(0, ceiling);
         if ($urandom_range(0, 9) < 7) slot = SlotWidth'($urandom_range(0, span - 1));
         else slot = SlotWidth'($urandom);
         send_fields(cmd, key, PosWidth'($urandom), PosWidth'($urandom), PosWidth'($urandom),
                     VelWidth'($urandom), $urandom, slot);
      end
   endtask

   // response side: per-beat hold, two long holds so the block backs up
   initial begin : drain
      int unsigned hold;
      int unsigned beats;
      beats = 0;
      forever begin
         hold = receiver_busy ? $urandom_range(0, IDLE_MAX) : 0;
         if (beats == 300 || beats == 1300) hold = LONG_HOLD;
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
      end
   end

   // run limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty store: reads at the lowest and highest slot (both out of range), unknown command, clear
      send_fields(CMD_READ, '0, '0, '0, '0, '0, '0, '0);
      send_fields(CMD_READ, '1, '1, '1, '1, '1, '1, '1);
      send_fields(CMD_UNUSED, '1, '1, '1, '1, 24'sh7FFFFF, '1, '1);
      send_fields(CMD_CLEAR, '1, '1, '1, '1, '1, '1, '0);
      // offers at field extremes, equal keys stop the sift-up
      send_fields(CMD_OFFER, '1, '1, '1, '1, 24'sh7FFFFF, '1, '0);
      send_fields(CMD_OFFER, '0, '0, '0, '0, 24'sh800000, '0, '1);
      send_fields(CMD_OFFER, '0, 24'h123456, 24'h654321, 24'hABCDEF, 24'sh000001, 32'h1, '0);
      send_fields(CMD_OFFER, 32'h8000_0000, 24'h800000, 24'h000001, 24'h7FFFFF,
                  24'shFFFFFF, 32'h8000_0001, '0);
      for (int s = 0; s < 5; s++) send_fields(CMD_READ, '0, '0, '0, '0, '0, '0, SlotWidth'(s));
      send_fields(CMD_UNUSED, 32'h5A5A_5A5A, '0, '1, '0, '0, '1, 10'd1);
      send_fields(CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0);
      send_fields(CMD_READ, '0, '0, '0, '0, '0, '0, '0);

      // zero target acts as one; keys at and above the ceiling, tie with the root
      write_register(CSR_TARGET_COUNT, '0);
      write_register(CSR_MASS_CEILING, 32'd100);
      send_fields(CMD_OFFER, 32'd101, '1, '1, '1, '1, '1, '0);
      send_fields(CMD_OFFER, 32'd100, 24'h1, 24'h2, 24'h3, 24'sh4, 32'h5, '0);
      send_fields(CMD_OFFER, 32'd100, 24'h6, 24'h7, 24'h8, 24'sh9, 32'hA, '0);
      send_fields(CMD_OFFER, 32'd50, 24'hB, 24'hC, 24'hD, 24'shE, 32'hF, '0);
      send_fields(CMD_OFFER, 32'd101, 24'h10, 24'h11, 24'h12, 24'sh13, 32'h14, '0);
      send_fields(CMD_READ, '0, '0, '0, '0, '0, '0, '0);

      // oversize target acts as full capacity; zero ceiling
      write_register(CSR_TARGET_COUNT, 32'd2047);
      write_register(CSR_MASS_CEILING, '0);
      send_fields(CMD_OFFER, '0, 24'h21, 24'h22, 24'h23, 24'sh24, 32'h25, '0);
      send_fields(CMD_OFFER, 32'd1, 24'h26, 24'h27, 24'h28, 24'sh29, 32'h2A, '0);
      send_fields(CMD_READ, '0, '0, '0, '0, '0, '0, 10'd1);

      // random phases: small targets, then a full store, then lowered and restored targets
      random_phase('1, 11'd1, 60, 2, 1'b1, 1'b1);
      random_phase($urandom, 11'd7, 150, 3, 1'b0, 1'b0);
      random_phase('1, 11'd33, 200, 2, 1'b1, 1'b0);
      random_phase('1, 11'd2047, 1150, 0, 1'b0, 1'b1);
      random_phase('1, 11'd5, 150, 0, 1'b1, 1'b1);
      random_phase(32'h8000_0000, 11'd100, 150, 3, 1'b0, 1'b1);
      random_phase('1, 11'd1024, 40, 2, 1'b1, 1'b0);

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
